[sv/pqfs_pkg.sv]
// Shared types and constants for the fast-scan accumulator.
// Used by the front, back and result stages, the top level and the testbench.
// Depends on nothing.
package pqfs_pkg;

	// Number of 4-bit codes carried by one code beat.
	localparam int CODE_LANES = 16;
	// Table entries per dimension, one for each 4-bit symbol.
	localparam int SYMBOLS = 16;
	// Default sizes handed to the top level.
	localparam int DEF_LANES = 16;
	localparam int DEF_MAX_DIM = 256;
	localparam int DEF_MAX_VECTORS = 16777216;
	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Reset values of the configuration registers.
	localparam logic [8:0] DIM_COUNT_RESET = 9'd256;
	localparam logic [24:0] VECTOR_COUNT_RESET = 25'd16777216;

	// Configuration register indexes.
	typedef enum logic {
		CFG_DIM_COUNT = 1'b0,
		CFG_VECTOR_COUNT = 1'b1
	} pqfs_cfg_t;

	// Input command codes.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_CODES = 1'b1
	} pqfs_cmd_t;

	// One classified item in the queue between the front and the back.
	typedef struct packed {
		pqfs_cmd_t command;
		logic store_en;
		logic [7:0] dim;
		logic [3:0] symbol;
		logic [7:0] value;
		logic [63:0] codes;
	} pqfs_entry_t;

	// A finished block handed to the result stage (sums travel beside it).
	typedef struct packed {
		logic valid;
		logic [23:0] base;
		logic [4:0] count;
	} pqfs_blk_t;

endpackage

[sv/pqfs_if.sv]
// Valid/ready channel interfaces for the item and result streams.
// Depends on nothing.
interface pqfs_item_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] table_dim;
	logic [3:0] table_symbol;
	logic [7:0] table_value;
	logic [63:0] lane_codes;

	modport source (output valid, command, table_dim, table_symbol, table_value, lane_codes,
		input ready);
	modport sink (input valid, command, table_dim, table_symbol, table_value, lane_codes,
		output ready);
endinterface

interface pqfs_result_if;
	logic valid;
	logic ready;
	logic [23:0] vector_index;
	logic [15:0] score_sum;
	logic last;

	modport source (output valid, vector_index, score_sum, last, input ready);
	modport sink (input valid, vector_index, score_sum, last, output ready);
endinterface

[sv/pq_fast_scan_accumulate.sv]
// Top level of the 4-bit product-quantization fast-scan accumulator.
// Depends on pqfs_pkg, pqfs_if, pqfs_front, pqfs_back and pqfs_emit.
//
// Usage:
//   items   - one beat per item: command 0 writes one table entry (dimension, symbol,
//             value) and restarts the scan; command 1 carries sixteen 4-bit lane codes
//             for the current dimension of the current block of vectors.
//   results - one beat per valid vector of a finished block: vector index, 16-bit sum
//             and a last mark on the final beat of the block.
//   cfg_we/cfg_index/cfg_data - register writes; the user must make them only while the
//             block is idle, which the block itself does not enforce.
// Throughput: one item a cycle while the accumulator stage is not stalled. A block end
// yields up to sixteen result beats, one per cycle from the result stage while the
// receiver is ready; a second block end arriving before those are sent waits in the
// accumulator stage, which then backs up the four-entry item queue. The first result of
// a block is offered once the item that ends it has passed the queue and the table read stage.
// Reset clears the scan position, the sums and one valid bit per table row, so the
// table reads as zero at once with no clearing pass. A stalled receiver holds the
// current result steady and the block keeps taking items until the queue is full.
module pq_fast_scan_accumulate
	import pqfs_pkg::*;
#(
	parameter int LANES = DEF_LANES,
	parameter int MAX_DIM = DEF_MAX_DIM,
	parameter int MAX_VECTORS = DEF_MAX_VECTORS
) (
	input logic clk,
	input logic arst_n,
	pqfs_item_if.sink items,
	pqfs_result_if.source results,
	input logic cfg_we,
	input logic cfg_index,
	input logic [24:0] cfg_data
);

	localparam int ACTIVE = (LANES < CODE_LANES) ? LANES : CODE_LANES;

	logic [8:0] dim_count_q;
	logic [24:0] vector_count_q;
	logic [8:0] dims;
	logic [24:0] nvec;
	logic q_valid;
	pqfs_entry_t q_entry;
	logic q_pop;
	logic take;
	pqfs_blk_t blk;
	logic [15:0] blk_sums [ACTIVE];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= DIM_COUNT_RESET;
			vector_count_q <= VECTOR_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (pqfs_cfg_t'(cfg_index))
				CFG_DIM_COUNT: dim_count_q <= cfg_data[8:0];
				CFG_VECTOR_COUNT: vector_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the counts to the supported range.
	always_comb begin
		if (dim_count_q == 9'd0) begin
			dims = 9'd1;
		end else if (dim_count_q > 9'(MAX_DIM)) begin
			dims = 9'(MAX_DIM);
		end else begin
			dims = dim_count_q;
		end
		nvec = (vector_count_q > 25'(MAX_VECTORS)) ? 25'(MAX_VECTORS) : vector_count_q;
	end

	pqfs_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop)
	);

	pqfs_back #(
		.LANES(LANES),
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop),
		.dims(dims),
		.nvec(nvec),
		.emit_take(take),
		.emit_blk(blk),
		.emit_sums(blk_sums)
	);

	pqfs_emit #(
		.LANES(LANES)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.blk(blk),
		.sums(blk_sums),
		.take(take),
		.results(results)
	);

endmodule

[sv/pqfs_front.sv]
// Front stage: accepts item beats, classifies them and holds them in a short queue.
// Depends on pqfs_pkg and pqfs_item_if.
module pqfs_front
	import pqfs_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input logic clk,
	input logic arst_n,
	pqfs_item_if.sink items,
	output logic q_valid,
	output pqfs_entry_t q_entry,
	input logic q_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pqfs_entry_t fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	pqfs_entry_t entry;
	logic push;

	// Classify the incoming beat; entries beyond the table are not stored.
	always_comb begin
		entry.command = pqfs_cmd_t'(items.command);
		entry.store_en = ({1'b0, items.table_dim} < 9'(MAX_DIM));
		entry.dim = items.table_dim;
		entry.symbol = items.table_symbol;
		entry.value = items.table_value;
		entry.codes = items.lane_codes;
	end

	assign items.ready = (cnt_q < CNT_W'(QUEUE_DEPTH));
	assign push = items.valid && items.ready;
	assign q_valid = (cnt_q != '0);
	assign q_entry = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The queue never holds more than its depth, and is never popped empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(QUEUE_DEPTH)) && (!q_pop || cnt_q != '0))
		else $error("front queue count out of range");

endmodule

[sv/pqfs_back.sv]
// Back stage: table memory, scan position tracking and the lane accumulators.
// Depends on pqfs_pkg.
module pqfs_back
	import pqfs_pkg::*;
#(
	parameter int LANES = DEF_LANES,
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input pqfs_entry_t q_entry,
	output logic q_pop,
	input logic [8:0] dims,
	input logic [24:0] nvec,
	input logic emit_take,
	output pqfs_blk_t emit_blk,
	output logic [15:0] emit_sums [(LANES < CODE_LANES) ? LANES : CODE_LANES]
);

	localparam int ACTIVE = (LANES < CODE_LANES) ? LANES : CODE_LANES;
	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ROW_W = 8 * SYMBOLS;

	// One row per dimension, one byte per symbol.
	logic [ROW_W-1:0] table_q [MAX_DIM];
	logic [MAX_DIM-1:0] row_valid_q;
	logic [DIM_W-1:0] dim_pos_q;
	logic [19:0] blk_q;
	logic [15:0] sums_q [ACTIVE];

	logic valid_s1;
	pqfs_cmd_t cmd_s1;
	logic end_s1;
	logic [23:0] base_s1;
	logic [4:0] cnt_s1;
	logic [63:0] codes_s1;
	logic [ROW_W-1:0] rdata_s1;
	logic rvalid_s1;

	logic stall;
	logic issue;
	logic is_load;
	logic is_codes;
	logic [DIM_W-1:0] wrow;
	logic [SYMBOLS-1:0] wbe;
	logic block_end;
	logic [24:0] base;
	logic [24:0] rem;
	logic [4:0] cnt;
	logic [15:0] new_sum [ACTIVE];

	// Hold the second stage while a finished block waits for the result stage.
	assign stall = valid_s1 && (cmd_s1 == CMD_CODES) && end_s1 && (cnt_s1 != '0) && !emit_take;
	assign issue = q_valid && !stall;
	assign q_pop = issue;
	assign is_load = issue && (q_entry.command == CMD_LOAD);
	assign is_codes = issue && (q_entry.command == CMD_CODES);
	assign wrow = q_entry.dim[DIM_W-1:0];

	// A row not yet written reads as zero, so its first write fills the whole row.
	always_comb begin
		for (int b = 0; b < SYMBOLS; b++) begin
			wbe[b] = !row_valid_q[wrow] || (q_entry.symbol == 4'(b));
		end
	end

	// Block end and the number of valid vectors in the block.
	always_comb begin
		block_end = ((9'(dim_pos_q) + 9'd1) >= dims);
		base = 25'(blk_q) * 25'(ACTIVE);
		rem = nvec - base;
		if (nvec > base) begin
			cnt = (rem >= 25'(ACTIVE)) ? 5'(ACTIVE) : rem[4:0];
		end else begin
			cnt = 5'd0;
		end
	end

	// Table memory: byte-enabled write, registered row read.
	always_ff @(posedge clk) begin
		if (is_load && q_entry.store_en) begin
			for (int b = 0; b < SYMBOLS; b++) begin
				if (wbe[b]) begin
					table_q[wrow][8*b +: 8] <= (q_entry.symbol == 4'(b)) ? q_entry.value : 8'd0;
				end
			end
		end
		if (is_codes) begin
			rdata_s1 <= table_q[dim_pos_q];
		end
	end

	// Payload of the second stage.
	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= q_entry.command;
			end_s1 <= block_end;
			base_s1 <= base[23:0];
			cnt_s1 <= cnt;
			codes_s1 <= q_entry.codes;
			rvalid_s1 <= row_valid_q[dim_pos_q];
		end
	end

	// Row valid bits and scan position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			dim_pos_q <= '0;
			blk_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (!stall) begin
				valid_s1 <= issue;
			end
			if (is_load) begin
				if (q_entry.store_en) begin
					row_valid_q[wrow] <= 1'b1;
				end
				dim_pos_q <= '0;
				blk_q <= '0;
			end else if (is_codes) begin
				if (block_end) begin
					dim_pos_q <= '0;
					blk_q <= blk_q + 20'd1;
				end else begin
					dim_pos_q <= dim_pos_q + 1'b1;
				end
			end
		end
	end

	// Lane lookups and wrapping adds.
	always_comb begin
		for (int t = 0; t < ACTIVE; t++) begin
			new_sum[t] = sums_q[t] + (rvalid_s1 ?
				16'(rdata_s1[8*codes_s1[4*t +: 4] +: 8]) : 16'd0);
		end
	end

	assign emit_sums = new_sum;
	assign emit_blk.valid = valid_s1 && (cmd_s1 == CMD_CODES) && end_s1 && (cnt_s1 != '0)
		&& emit_take;
	assign emit_blk.base = base_s1;
	assign emit_blk.count = cnt_s1;

	// Lane sums: a load or a finished block clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < ACTIVE; t++) begin
				sums_q[t] <= '0;
			end
		end else if (valid_s1 && !stall) begin
			for (int t = 0; t < ACTIVE; t++) begin
				if (cmd_s1 == CMD_LOAD || end_s1) begin
					sums_q[t] <= '0;
				end else begin
					sums_q[t] <= new_sum[t];
				end
			end
		end
	end

	// Written rows stay written.
	assert property (@(posedge clk) disable iff (!arst_n)
		((row_valid_q & $past(row_valid_q)) == $past(row_valid_q)))
		else $error("table row lost its valid bit");

	// A load clears the accumulators behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 == CMD_LOAD) |=> (sums_q[0] == 16'd0))
		else $error("lane sum not cleared by load");

endmodule

[sv/pqfs_emit.sv]
// Result stage: holds the sums of a finished block and sends one result a beat.
// Depends on pqfs_pkg and pqfs_result_if.
module pqfs_emit
	import pqfs_pkg::*;
#(
	parameter int LANES = DEF_LANES
) (
	input logic clk,
	input logic arst_n,
	input pqfs_blk_t blk,
	input logic [15:0] sums [(LANES < CODE_LANES) ? LANES : CODE_LANES],
	output logic take,
	pqfs_result_if.source results
);

	localparam int ACTIVE = (LANES < CODE_LANES) ? LANES : CODE_LANES;
	localparam int PTR_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	logic busy_q;
	logic [3:0] ptr_q;
	logic [4:0] cnt_q;
	logic [23:0] base_q;
	logic [15:0] sums_q [ACTIVE];
	logic is_last;
	logic beat;

	assign is_last = ((5'(ptr_q) + 5'd1) == cnt_q);
	assign beat = results.valid && results.ready;
	// Free now, or freed by the final beat of the current block.
	assign take = !busy_q || (beat && is_last);

	assign results.valid = busy_q;
	assign results.vector_index = base_q + 24'(ptr_q);
	assign results.score_sum = sums_q[ptr_q[PTR_W-1:0]];
	assign results.last = is_last;

	// Captured block.
	always_ff @(posedge clk) begin
		if (blk.valid) begin
			base_q <= blk.base;
			cnt_q <= blk.count;
			sums_q <= sums;
		end
	end

	// Walk the valid lanes of the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ptr_q <= '0;
		end else if (blk.valid) begin
			busy_q <= 1'b1;
			ptr_q <= '0;
		end else if (beat) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			ptr_q <= ptr_q + 4'd1;
		end
	end

	// A held block always has a lane left to send.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 5'd0) && (5'(ptr_q) < cnt_q))
		else $error("result pointer outside the block");

	// A block is only taken when the stage is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		blk.valid |-> take)
		else $error("block handed over while results still pending");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pq_fast_scan_accumulate: a clocked driver, receiver and checker
// around a scoring model that predicts every result beat from the accepted item beats.
// Depends on pqfs_pkg, pqfs_if and the block itself.
module tb_top;
	import pqfs_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 7;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam longint unsigned VEC_LIMIT = DEF_MAX_VECTORS;

	typedef struct packed {
		pqfs_cmd_t command;
		logic [7:0] dim;
		logic [3:0] symbol;
		logic [7:0] value;
		logic [63:0] codes;
	} scan_item_t;

	typedef struct packed {
		logic [23:0] vector_index;
		logic [15:0] score_sum;
		logic last;
	} score_t;

	// Everything driven into the block starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic drv_valid = 1'b0;
	scan_item_t drv_item = '0;
	logic rx_ready = 1'b0;
	logic cfg_we = 1'b0;
	pqfs_cfg_t cfg_index = CFG_DIM_COUNT;
	logic [24:0] cfg_data = '0;

	// Scoring model state: table, lane sums, scan position and register copies.
	logic [7:0] dist_table [SYMBOLS * DEF_MAX_DIM] = '{default: 8'h00};
	logic [15:0] lane_acc [CODE_LANES] = '{default: 16'h0000};
	logic [7:0] scan_dim = '0;
	logic [19:0] block_idx = '0;
	logic [8:0] cfg_dims = DIM_COUNT_RESET;
	logic [24:0] cfg_vectors = VECTOR_COUNT_RESET;

	scan_item_t scan_items [$];
	score_t pending_scores [$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_served = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_wait = 0;
	bit no_gaps = 1'b0;

	pqfs_item_if item_ch ();
	pqfs_result_if result_ch ();

	assign item_ch.valid = drv_valid;
	assign item_ch.command = drv_item.command;
	assign item_ch.table_dim = drv_item.dim;
	assign item_ch.table_symbol = drv_item.symbol;
	assign item_ch.table_value = drv_item.value;
	assign item_ch.lane_codes = drv_item.codes;
	assign result_ch.ready = rx_ready;

	pq_fast_scan_accumulate dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.results(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Idle length for either side: mostly none, often short, now and then long.
	function automatic int unsigned idle_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (no_gaps) return 0;
		if (pick < 65) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		if (pick < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Applies one accepted item to the model and queues the result beats it causes.
	function automatic void accumulate_item(input scan_item_t it);
		int unsigned dims;
		longint unsigned nvec;
		longint unsigned base;
		longint unsigned top;
		logic [3:0] code;
		dims = (cfg_dims == 0) ? 1 : ((cfg_dims > DEF_MAX_DIM) ? DEF_MAX_DIM : cfg_dims);
		nvec = (cfg_vectors > VEC_LIMIT) ? VEC_LIMIT : cfg_vectors;
		if (it.command == CMD_LOAD) begin
			// The dimension field is 8 bits wide, so every write lands in the table.
			dist_table[{it.dim, it.symbol}] = it.value;
			for (int t = 0; t < CODE_LANES; t++) lane_acc[t] = '0;
			scan_dim = '0;
			block_idx = '0;
			return;
		end
		for (int t = 0; t < CODE_LANES; t++) begin
			code = it.codes[4*t +: 4];
			lane_acc[t] = lane_acc[t] + {8'h00, dist_table[{scan_dim, code}]};
		end
		if (int'(scan_dim) + 1 < dims) begin
			scan_dim = scan_dim + 8'd1;
			return;
		end
		// Block end: valid lanes run contiguously from lane 0, the highest one is marked.
		base = longint'(block_idx) * CODE_LANES;
		if (base < nvec) begin
			top = (nvec - base >= CODE_LANES) ? CODE_LANES - 1 : nvec - base - 1;
			for (int t = 0; t <= top; t++)
				pending_scores.push_back('{vector_index: 24'(base + t),
					score_sum: lane_acc[t], last: (t == top)});
		end
		for (int t = 0; t < CODE_LANES; t++) lane_acc[t] = '0;
		scan_dim = '0;
		block_idx = block_idx + 20'd1;
	endfunction

	function automatic void push_load(input logic [7:0] dim, input logic [3:0] symbol,
		input logic [7:0] value);
		scan_item_t it;
		it.command = CMD_LOAD;
		it.dim = dim;
		it.symbol = symbol;
		it.value = value;
		it.codes = {$urandom, $urandom};
		scan_items.push_back(it);
	endfunction

	function automatic void push_codes(input logic [63:0] codes);
		scan_item_t it;
		it.command = CMD_CODES;
		it.dim = 8'($urandom);
		it.symbol = 4'($urandom);
		it.value = 8'($urandom);
		it.codes = codes;
		scan_items.push_back(it);
	endfunction

	// Mostly code beats; loads aim at the dimensions in use but now and then anywhere.
	function automatic void push_random(input int unsigned span, input int unsigned load_pct);
		logic [7:0] dim;
		logic [7:0] value;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 99) < load_pct) begin
			dim = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, span - 1));
			value = (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hFF : 8'($urandom));
			push_load(dim, 4'($urandom), value);
		end else begin
			case (pick)
				0: push_codes('0);
				1: push_codes('1);
				default: push_codes({$urandom, $urandom});
			endcase
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Register write; only called with the block idle, so the model copy follows at once.
	task automatic write_reg(input pqfs_cfg_t idx, input logic [24:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DIM_COUNT) cfg_dims = data[8:0];
		else cfg_vectors = data;
		@(negedge clk);
	endtask

	// Waits until every item is taken and every result beat has come, then a little more.
	task automatic wait_drain();
		while (scan_items.size() != 0 || drv_valid || pending_scores.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input logic [8:0] dims, input logic [24:0] vecs,
		input int unsigned count, input int unsigned load_pct);
		int unsigned span;
		span = (dims == 0) ? 1 : ((dims > DEF_MAX_DIM) ? DEF_MAX_DIM : dims);
		write_reg(CFG_DIM_COUNT, 25'(dims));
		write_reg(CFG_VECTOR_COUNT, vecs);
		repeat (count) push_random(span, load_pct);
		wait_drain();
	endtask

	// Item driver: a new beat is offered once the previous one is taken and any gap is over.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			tx_gap <= 0;
		end else if (!drv_valid || item_ch.ready) begin
			if (tx_gap != 0) begin
				drv_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (scan_items.size() != 0) begin
				drv_item <= scan_items.pop_front();
				drv_valid <= 1'b1;
				tx_gap <= idle_length();
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus long hold-offs when asked for.
	always @(posedge clk or negedge arst_n) begin : rx_side
		int unsigned len;
		if (!arst_n) begin
			rx_ready <= 1'b0;
			rx_wait <= 0;
		end else if (rx_wait != 0) begin
			rx_ready <= 1'b0;
			rx_wait <= rx_wait - 1;
		end else if (holds_served != holds_asked) begin
			rx_ready <= 1'b0;
			rx_wait <= LONG_HOLD;
			holds_served <= holds_served + 1;
		end else begin
			len = idle_length();
			rx_ready <= (len == 0);
			rx_wait <= (len == 0) ? 0 : len - 1;
		end
	end

	// Checker: result beats against the oldest expectation, then item beats into the model.
	always @(posedge clk) begin : score_check
		score_t want;
		if (arst_n) begin
			if (result_ch.valid && rx_ready) begin
				if (pending_scores.size() == 0) begin
					report_mismatch("result beat with nothing expected, index",
						32'(result_ch.vector_index), 32'h0);
				end else begin
					want = pending_scores.pop_front();
					if (result_ch.vector_index !== want.vector_index)
						report_mismatch("vector_index", 32'(result_ch.vector_index),
							32'(want.vector_index));
					if (result_ch.score_sum !== want.score_sum)
						report_mismatch("score_sum", 32'(result_ch.score_sum),
							32'(want.score_sum));
					if (result_ch.last !== want.last)
						report_mismatch("last", 32'(result_ch.last), 32'(want.last));
				end
			end
			if (drv_valid && item_ch.ready) accumulate_item(drv_item);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extreme table entries, a full block, a partial block and an empty one.
		write_reg(CFG_DIM_COUNT, 25'd2);
		write_reg(CFG_VECTOR_COUNT, 25'd20);
		push_load(8'd0, 4'h0, 8'hFF);
		push_load(8'd0, 4'hF, 8'h80);
		push_load(8'd1, 4'hF, 8'hFF);
		push_load(8'd1, 4'h0, 8'h01);
		push_load(8'd255, 4'hF, 8'hFF);
		push_load(8'hAA, 4'hA, 8'h55);
		push_codes(64'h0);
		push_codes('1);
		push_codes(64'h0F0F_0F0F_0F0F_0F0F);
		push_codes(64'hF0F0_F0F0_F0F0_F0F0);
		push_codes({$urandom, $urandom});
		push_codes({$urandom, $urandom});
		// A load in the middle of a block restarts the scan at block 0.
		push_codes({$urandom, $urandom});
		push_load(8'd1, 4'h5, 8'h33);
		push_codes('1);
		push_codes(64'h0123_4567_89AB_CDEF);
		wait_drain();

		// Lowering the dimension count below the scan position ends the block at once.
		write_reg(CFG_DIM_COUNT, 25'd4);
		push_codes({$urandom, $urandom});
		push_codes({$urandom, $urandom});
		wait_drain();
		write_reg(CFG_DIM_COUNT, 25'd2);
		push_codes({$urandom, $urandom});
		wait_drain();

		// Dimension count zero acts as one; vector count zero yields no result at all.
		write_reg(CFG_DIM_COUNT, 25'd0);
		write_reg(CFG_VECTOR_COUNT, 25'd0);
		push_codes({$urandom, $urandom});
		push_codes({$urandom, $urandom});
		wait_drain();
		write_reg(CFG_VECTOR_COUNT, 25'd1);
		push_load(8'd0, 4'h3, 8'h07);
		push_codes(64'h3333_3333_3333_3333);
		wait_drain();

		// One result burst per code beat with the receiver held off, so the input backs up.
		write_reg(CFG_DIM_COUNT, 25'd1);
		write_reg(CFG_VECTOR_COUNT, VECTOR_COUNT_RESET);
		no_gaps = 1'b1;
		holds_asked = holds_asked + 1;
		repeat (24) push_random(1, 10);
		wait_drain();
		no_gaps = 1'b0;

		random_phase(9'd3, 25'd37, 20, 12);
		random_phase(9'd0, 25'h1FF_FFFF, 18, 12);
		random_phase(9'd5, 25'd1, 18, 10);
		random_phase(9'd2, 25'd0, 12, 12);

		// The sender stops half way until every result has been taken.
		write_reg(CFG_DIM_COUNT, 25'd7);
		write_reg(CFG_VECTOR_COUNT, 25'd300);
		repeat (12) push_random(7, 8);
		wait_drain();
		repeat (12) push_random(7, 8);
		wait_drain();

		// A dimension count above the table size is taken as the table size.
		random_phase(9'h1FF, 25'd40, 15, 10);

		random_phase(9'd4, 25'd50, 18, 10);

		if (error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
sv/pqfs_pkg.sv
sv/pqfs_if.sv
sv/pqfs_front.sv
sv/pqfs_back.sv
sv/pqfs_emit.sv
sv/pq_fast_scan_accumulate.sv
tb/sv/tb_top.sv
